[rtl/escc_pkg.sv]
// ----------------------------------------------------------------------------
// escc_pkg
// Shared types, range limits and reciprocal constants for the epoch seconds
// calendar converter.
// ----------------------------------------------------------------------------
package escc_pkg;

	// stages after the input register for each conversion path
	localparam int CAL_LAT = 11;
	localparam int SEC_LAT = 8;

	localparam logic signed [39:0] SEC_MIN = -40'sd62135596800;
	localparam logic signed [39:0] SEC_MAX = 40'sd253402300799;
	localparam logic [19:0] USEC_PER_SEC = 20'd1000000;

	// reciprocals: ceil(2^s / d), exact floor quotient for the stated input width
	localparam logic [9:0]  R100 = 10'(((64'd1 << 16) + 64'd99) / 64'd100);   // 9-bit input
	localparam logic [11:0] R5   = 12'(((64'd1 << 14) + 64'd4) / 64'd5);      // 11-bit input
	localparam logic [22:0] R7   = 23'(((64'd1 << 25) + 64'd6) / 64'd7);      // 22-bit input

	typedef struct packed {
		logic signed [38:0] epoch_seconds;
		logic signed [20:0] fraction_us;
	} cal_in_t;

	typedef struct packed {
		logic [13:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic [5:0]  hour;
		logic [5:0]  minute;
		logic [5:0]  second;
		logic [9:0]  milli;
		logic [9:0]  micro;
	} sec_in_t;

	typedef struct packed {
		logic        ok;
		logic [13:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [5:0]  second;
		logic [9:0]  milli;
		logic [9:0]  micro;
		logic [2:0]  weekday;
	} cal_res_t;

	typedef struct packed {
		logic               ok;
		logic signed [38:0] seconds;
		logic signed [20:0] fraction;
		logic [2:0]         weekday;
	} sec_res_t;

	typedef struct packed {
		logic vld;
		logic func;
	} ctl_t;

	// days in a zero-based month, zero for codes that are no month
	function automatic logic [4:0] month_len(input logic [3:0] mon, input logic leap);
		logic [4:0] len;
		case (mon)
			4'd0, 4'd2, 4'd4, 4'd6, 4'd7, 4'd9, 4'd11: len = 5'd31;
			4'd3, 4'd5, 4'd8, 4'd10: len = 5'd30;
			4'd1: len = leap ? 5'd29 : 5'd28;
			default: len = 5'd0;
		endcase
		return len;
	endfunction

endpackage

[rtl/epoch_seconds_calendar_converter_unit.sv]
// ----------------------------------------------------------------------------
// epoch_seconds_calendar_converter_unit
// Converts between signed epoch seconds plus microseconds and proleptic
// Gregorian UTC calendar fields, in either direction per beat.
// ----------------------------------------------------------------------------
// usage
//   a command beat is taken at each rising edge with start high and busy low;
//   busy stays low, so a new beat may enter in every cycle
//   func 0: epoch_seconds and fraction_us give year, zero-based month and day,
//     hour, minute, second, milli, micro and weekday
//   func 1: the calendar inputs give seconds_out, fraction_out and weekday
//   one result beat per command, shown for exactly one cycle with done high
//   result path: input register, eleven arithmetic stages of the date path and
//     output register; done rises with the registered result
//   throughput: one beat per cycle; each stage holds at most two constant-
//     reciprocal multipliers of at most 33 bits
//   ok low marks bad fields or a range fault; every result field is then zero
//   fields of the unused direction read zero
//   reset clears only the beat valid and direction lines and done; no beat survives it
//   the receiver cannot hold results off, so nothing ever waits here
// ----------------------------------------------------------------------------
module epoch_seconds_calendar_converter_unit
	import escc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               func,
	input  logic signed [38:0] epoch_seconds,
	input  logic signed [20:0] fraction_us,
	input  logic [13:0]        year_in,
	input  logic [3:0]         month_in,
	input  logic [4:0]         day_in,
	input  logic [5:0]         hour_in,
	input  logic [5:0]         minute_in,
	input  logic [5:0]         second_in,
	input  logic [9:0]         milli_in,
	input  logic [9:0]         micro_in,
	output logic               done,
	output logic               ok,
	output logic signed [38:0] seconds_out,
	output logic signed [20:0] fraction_out,
	output logic [13:0]        year_out,
	output logic [3:0]         month_out,
	output logic [4:0]         day_out,
	output logic [4:0]         hour_out,
	output logic [5:0]         minute_out,
	output logic [5:0]         second_out,
	output logic [9:0]         milli_out,
	output logic [9:0]         micro_out,
	output logic [2:0]         weekday
);

	localparam int OUT_LAT = CAL_LAT + 2;

	// fully pipelined, never stalls
	assign busy = 1'b0;

	// input register, payload captured every cycle
	cal_in_t cin_s1;
	sec_in_t sin_s1;

	always_ff @(posedge clk) begin
		cin_s1.epoch_seconds <= epoch_seconds;
		cin_s1.fraction_us   <= fraction_us;
		sin_s1.year          <= year_in;
		sin_s1.month         <= month_in;
		sin_s1.day           <= day_in;
		sin_s1.hour          <= hour_in;
		sin_s1.minute        <= minute_in;
		sin_s1.second        <= second_in;
		sin_s1.milli         <= milli_in;
		sin_s1.micro         <= micro_in;
	end

	// beat valid and direction travel beside the two arithmetic paths
	ctl_t ctl_q [CAL_LAT+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= CAL_LAT; i++) begin
				ctl_q[i] <= '0;
			end
		end else begin
			ctl_q[0].vld  <= start && !busy;
			ctl_q[0].func <= func;
			for (int i = 1; i <= CAL_LAT; i++) begin
				ctl_q[i] <= ctl_q[i-1];
			end
		end
	end

	cal_res_t cres;
	sec_res_t sres;

	escc_to_cal u_to_cal (
		.clk   (clk),
		.in_s1 (cin_s1),
		.res   (cres)
	);

	escc_to_sec u_to_sec (
		.clk   (clk),
		.in_s1 (sin_s1),
		.res   (sres)
	);

	// result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= ctl_q[CAL_LAT].vld;
		end
	end

	// result register: pick the direction, zero what is unused or failed
	always_ff @(posedge clk) begin
		ok           <= 1'b0;
		seconds_out  <= '0;
		fraction_out <= '0;
		year_out     <= '0;
		month_out    <= '0;
		day_out      <= '0;
		hour_out     <= '0;
		minute_out   <= '0;
		second_out   <= '0;
		milli_out    <= '0;
		micro_out    <= '0;
		weekday      <= '0;
		if (!ctl_q[CAL_LAT].func) begin
			if (cres.ok) begin
				ok         <= 1'b1;
				year_out   <= cres.year;
				month_out  <= cres.month;
				day_out    <= cres.day;
				hour_out   <= cres.hour;
				minute_out <= cres.minute;
				second_out <= cres.second;
				milli_out  <= cres.milli;
				micro_out  <= cres.micro;
				weekday    <= cres.weekday;
			end
		end else begin
			if (sres.ok) begin
				ok           <= 1'b1;
				seconds_out  <= sres.seconds;
				fraction_out <= sres.fraction;
				weekday      <= sres.weekday;
			end
		end
	end

	// every result beat stems from a command beat a fixed latency back
	a_done_has_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, OUT_LAT))
		else $error("result beat without command beat");

	a_cmd_gives_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##OUT_LAT done)
		else $error("command beat lost");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !ok) |-> (seconds_out == 39'sd0 && fraction_out == 21'sd0
			&& year_out == 14'd0 && weekday == 3'd0))
		else $error("failed result not cleared");

	a_frac_sign: assert property (@(posedge clk) disable iff (!arst_n)
		(done && ok && fraction_out < 21'sd0) |-> (seconds_out <= 39'sd0))
		else $error("negative fraction with positive seconds");

	a_one_direction: assert property (@(posedge clk) disable iff (!arst_n)
		(done && ok && year_out != 14'd0) |-> (seconds_out == 39'sd0
			&& fraction_out == 21'sd0))
		else $error("both directions in one result");

endmodule

[rtl/escc_to_cal.sv]
// ----------------------------------------------------------------------------
// escc_to_cal
// Pipelined split of signed epoch seconds and microseconds into a proleptic
// Gregorian date, time of day and weekday.
// ----------------------------------------------------------------------------
module escc_to_cal
	import escc_pkg::*;
(
	input  logic     clk,
	input  cal_in_t  in_s1,
	output cal_res_t res
);

	localparam logic [32:0] R675    = 33'(((64'd1 << 42) + 64'd674) / 64'd675);
	localparam logic [22:0] R146097 = 23'(((64'd1 << 40) + 64'd146096) / 64'd146097);
	localparam logic [20:0] R1000   = 21'(((64'd1 << 30) + 64'd999) / 64'd1000);
	localparam logic [17:0] R3600   = 18'(((64'd1 << 29) + 64'd3599) / 64'd3600);
	localparam logic [18:0] R1460   = 19'(((64'd1 << 29) + 64'd1459) / 64'd1460);
	localparam logic [18:0] R36524  = 19'(((64'd1 << 34) + 64'd36523) / 64'd36524);
	localparam logic [12:0] R60     = 13'(((64'd1 << 18) + 64'd59) / 64'd60);
	localparam logic [18:0] R365    = 19'(((64'd1 << 27) + 64'd364) / 64'd365);
	localparam logic [11:0] R153    = 12'(((64'd1 << 19) + 64'd152) / 64'd153);

	// stage 2: borrow and range
	logic               neg;
	logic signed [39:0] sec_b, u40;
	logic signed [21:0] us_sum;
	logic               ok_s2;
	logic [38:0]        u_s2;
	logic [19:0]        us_s2;

	always_comb begin
		neg    = in_s1.fraction_us[20];
		sec_b  = $signed({in_s1.epoch_seconds[38], in_s1.epoch_seconds})
			- $signed({39'd0, neg});
		us_sum = 22'(in_s1.fraction_us) + (neg ? 22'sd1000000 : 22'sd0);
		u40    = sec_b - SEC_MIN;
	end

	always_ff @(posedge clk) begin
		ok_s2 <= (in_s1.fraction_us >= -21'sd999999) && (in_s1.fraction_us <= 21'sd999999)
			&& (sec_b >= SEC_MIN) && (sec_b <= SEC_MAX);
		u_s2  <= u40[38:0];
		us_s2 <= us_sum[19:0];
	end

	// stage 3: day count since year 1, milliseconds
	logic [64:0] pd;
	logic [40:0] pu;
	logic        ok_s3;
	logic [21:0] d_s3;
	logic [38:0] u_s3;
	logic [19:0] us_s3;
	logic [9:0]  ms_s3;

	assign pd = u_s2[38:7] * R675;
	assign pu = us_s2 * R1000;

	always_ff @(posedge clk) begin
		ok_s3 <= ok_s2;
		d_s3  <= pd[63:42];
		u_s3  <= u_s2;
		us_s3 <= us_s2;
		ms_s3 <= pu[39:30];
	end

	// stage 4: second of day, era, weekday quotient
	logic [38:0] rem39;
	logic [19:0] mc20;
	logic [21:0] z, d1;
	logic [44:0] pe, pw;
	logic        ok_s4;
	logic [16:0] rem_s4;
	logic [21:0] z_s4, d1_s4;
	logic [4:0]  era_s4;
	logic [18:0] wq_s4;
	logic [9:0]  ms_s4, mc_s4;

	always_comb begin
		rem39 = u_s3 - 39'(d_s3) * 39'd86400;
		mc20  = us_s3 - 20'(ms_s3) * 20'd1000;
		z     = d_s3 + 22'd306;
		d1    = d_s3 + 22'd1;
		pe    = z * R146097;
		pw    = d1 * R7;
	end

	always_ff @(posedge clk) begin
		ok_s4  <= ok_s3;
		rem_s4 <= rem39[16:0];
		z_s4   <= z;
		d1_s4  <= d1;
		era_s4 <= pe[44:40];
		wq_s4  <= pw[43:25];
		ms_s4  <= ms_s3;
		mc_s4  <= mc20[9:0];
	end

	// stage 5: day of era, weekday, hour
	logic [21:0] doe22, wd22;
	logic [34:0] ph;
	logic        ok_s5;
	logic [17:0] doe_s5;
	logic [4:0]  era_s5, hour_s5;
	logic [16:0] rem_s5;
	logic [2:0]  wd_s5;
	logic [9:0]  ms_s5, mc_s5;

	always_comb begin
		doe22 = z_s4 - 22'(era_s4) * 22'd146097;
		wd22  = d1_s4 - 22'(wq_s4) * 22'd7;
		ph    = rem_s4 * R3600;
	end

	always_ff @(posedge clk) begin
		ok_s5   <= ok_s4;
		doe_s5  <= doe22[17:0];
		era_s5  <= era_s4;
		hour_s5 <= ph[33:29];
		rem_s5  <= rem_s4;
		wd_s5   <= wd22[2:0];
		ms_s5   <= ms_s4;
		mc_s5   <= mc_s4;
	end

	// stage 6: leap corrections inside the era
	logic [36:0] p1, p2;
	logic [16:0] r2_17;
	logic        ok_s6, c3_s6;
	logic [17:0] doe_s6;
	logic [6:0]  c1_s6;
	logic [2:0]  c2_s6;
	logic [4:0]  era_s6, hour_s6;
	logic [11:0] r2_s6;
	logic [2:0]  wd_s6;
	logic [9:0]  ms_s6, mc_s6;

	always_comb begin
		p1    = doe_s5 * R1460;
		p2    = doe_s5 * R36524;
		r2_17 = rem_s5 - 17'(hour_s5) * 17'd3600;
	end

	always_ff @(posedge clk) begin
		ok_s6   <= ok_s5;
		doe_s6  <= doe_s5;
		c1_s6   <= p1[35:29];
		c2_s6   <= p2[36:34];
		c3_s6   <= (doe_s5 == 18'd146096);
		era_s6  <= era_s5;
		hour_s6 <= hour_s5;
		r2_s6   <= r2_17[11:0];
		wd_s6   <= wd_s5;
		ms_s6   <= ms_s5;
		mc_s6   <= mc_s5;
	end

	// stage 7: day numerator for year of era, minute
	logic [24:0] pm;
	logic        ok_s7;
	logic [17:0] t_s7, doe_s7;
	logic [4:0]  era_s7, hour_s7;
	logic [11:0] r2_s7;
	logic [5:0]  min_s7;
	logic [2:0]  wd_s7;
	logic [9:0]  ms_s7, mc_s7;

	assign pm = r2_s6 * R60;

	always_ff @(posedge clk) begin
		ok_s7   <= ok_s6;
		t_s7    <= doe_s6 - 18'(c1_s6) + 18'(c2_s6) - 18'(c3_s6);
		doe_s7  <= doe_s6;
		era_s7  <= era_s6;
		hour_s7 <= hour_s6;
		r2_s7   <= r2_s6;
		min_s7  <= pm[23:18];
		wd_s7   <= wd_s6;
		ms_s7   <= ms_s6;
		mc_s7   <= mc_s6;
	end

	// stage 8: year of era, second
	logic [36:0] py;
	logic [11:0] sec12;
	logic        ok_s8;
	logic [8:0]  yoe_s8;
	logic [17:0] doe_s8;
	logic [4:0]  era_s8, hour_s8;
	logic [5:0]  min_s8, sec_s8;
	logic [2:0]  wd_s8;
	logic [9:0]  ms_s8, mc_s8;

	always_comb begin
		py    = t_s7 * R365;
		sec12 = r2_s7 - 12'(min_s7) * 12'd60;
	end

	always_ff @(posedge clk) begin
		ok_s8   <= ok_s7;
		yoe_s8  <= py[35:27];
		doe_s8  <= doe_s7;
		era_s8  <= era_s7;
		hour_s8 <= hour_s7;
		min_s8  <= min_s7;
		sec_s8  <= sec12[5:0];
		wd_s8   <= wd_s7;
		ms_s8   <= ms_s7;
		mc_s8   <= mc_s7;
	end

	// stage 9: centuries in era, march-based year
	logic [18:0] pq;
	logic        ok_s9;
	logic [8:0]  yoe_s9;
	logic [1:0]  yq_s9;
	logic [13:0] y_s9;
	logic [17:0] doe_s9;
	logic [4:0]  hour_s9;
	logic [5:0]  min_s9, sec_s9;
	logic [2:0]  wd_s9;
	logic [9:0]  ms_s9, mc_s9;

	assign pq = yoe_s8 * R100;

	always_ff @(posedge clk) begin
		ok_s9   <= ok_s8;
		yoe_s9  <= yoe_s8;
		yq_s9   <= pq[17:16];
		y_s9    <= 14'(yoe_s8) + 14'(era_s8) * 14'd400;
		doe_s9  <= doe_s8;
		hour_s9 <= hour_s8;
		min_s9  <= min_s8;
		sec_s9  <= sec_s8;
		wd_s9   <= wd_s8;
		ms_s9   <= ms_s8;
		mc_s9   <= mc_s8;
	end

	// stage 10: day of march-based year
	logic [17:0] doy18;
	logic        ok_s10;
	logic [8:0]  doy_s10;
	logic [13:0] y_s10;
	logic [4:0]  hour_s10;
	logic [5:0]  min_s10, sec_s10;
	logic [2:0]  wd_s10;
	logic [9:0]  ms_s10, mc_s10;

	assign doy18 = doe_s9 - (18'(yoe_s9) * 18'd365 + 18'(yoe_s9[8:2]) - 18'(yq_s9));

	always_ff @(posedge clk) begin
		ok_s10   <= ok_s9;
		doy_s10  <= doy18[8:0];
		y_s10    <= y_s9;
		hour_s10 <= hour_s9;
		min_s10  <= min_s9;
		sec_s10  <= sec_s9;
		wd_s10   <= wd_s9;
		ms_s10   <= ms_s9;
		mc_s10   <= mc_s9;
	end

	// stage 11: march-based month
	logic [10:0] k1;
	logic [22:0] pmp;
	logic        ok_s11;
	logic [3:0]  mp_s11;
	logic [8:0]  doy_s11;
	logic [13:0] y_s11;
	logic [4:0]  hour_s11;
	logic [5:0]  min_s11, sec_s11;
	logic [2:0]  wd_s11;
	logic [9:0]  ms_s11, mc_s11;

	always_comb begin
		k1  = 11'(doy_s10) * 11'd5 + 11'd2;
		pmp = k1 * R153;
	end

	always_ff @(posedge clk) begin
		ok_s11   <= ok_s10;
		mp_s11   <= pmp[22:19];
		doy_s11  <= doy_s10;
		y_s11    <= y_s10;
		hour_s11 <= hour_s10;
		min_s11  <= min_s10;
		sec_s11  <= sec_s10;
		wd_s11   <= wd_s10;
		ms_s11   <= ms_s10;
		mc_s11   <= mc_s10;
	end

	// stage 12: day of month and civil month and year
	logic [10:0] k2;
	logic [22:0] p5;
	logic [8:0]  day9;
	logic        jan_feb;

	always_comb begin
		k2      = 11'(mp_s11) * 11'd153 + 11'd2;
		p5      = k2 * R5;
		day9    = doy_s11 - p5[22:14];
		jan_feb = (mp_s11 >= 4'd10);
	end

	always_ff @(posedge clk) begin
		res.ok      <= ok_s11;
		res.year    <= y_s11 + 14'(jan_feb);
		res.month   <= jan_feb ? mp_s11 - 4'd10 : mp_s11 + 4'd2;
		res.day     <= day9[4:0];
		res.hour    <= hour_s11;
		res.minute  <= min_s11;
		res.second  <= sec_s11;
		res.milli   <= ms_s11;
		res.micro   <= mc_s11;
		res.weekday <= wd_s11;
	end

endmodule

[rtl/escc_to_sec.sv]
// ----------------------------------------------------------------------------
// escc_to_sec
// Pipelined check of calendar fields and conversion to epoch seconds,
// microseconds and weekday, delayed to line up with the date path.
// ----------------------------------------------------------------------------
module escc_to_sec
	import escc_pkg::*;
(
	input  logic     clk,
	input  sec_in_t  in_s1,
	output sec_res_t res
);

	localparam int PAD = CAL_LAT - SEC_LAT;
	localparam logic [14:0] R100Y = 15'(((64'd1 << 21) + 64'd99) / 64'd100);
	localparam logic [14:0] R400  = 15'(((64'd1 << 23) + 64'd399) / 64'd400);

	// stage 2: field checks, march-based year and month
	logic [28:0] pq100;
	logic        ok_s2;
	logic [13:0] yr_s2, y_s2;
	logic [6:0]  q100_s2;
	logic [3:0]  mp_s2, mon_s2;
	logic [4:0]  day_s2;
	logic [16:0] hms_s2;
	logic [19:0] us_s2;

	assign pq100 = in_s1.year * R100Y;

	always_ff @(posedge clk) begin
		ok_s2   <= (in_s1.year >= 14'd1) && (in_s1.year <= 14'd9999)
			&& (in_s1.month <= 4'd11) && (in_s1.hour <= 6'd23)
			&& (in_s1.minute <= 6'd59) && (in_s1.second <= 6'd59)
			&& (in_s1.milli <= 10'd999) && (in_s1.micro <= 10'd999);
		yr_s2   <= in_s1.year;
		q100_s2 <= pq100[27:21];
		y_s2    <= in_s1.year - 14'(in_s1.month <= 4'd1);
		mp_s2   <= (in_s1.month >= 4'd2) ? in_s1.month - 4'd2 : in_s1.month + 4'd10;
		mon_s2  <= in_s1.month;
		day_s2  <= in_s1.day;
		hms_s2  <= 17'(in_s1.hour) * 17'd3600 + 17'(in_s1.minute) * 17'd60
			+ 17'(in_s1.second);
		us_s2   <= 20'(in_s1.milli) * 20'd1000 + 20'(in_s1.micro);
	end

	// stage 3: century remainder, era, day offset of month
	logic [13:0] r100_14;
	logic [28:0] pera;
	logic [10:0] k;
	logic [22:0] pk;
	logic        ok_s3;
	logic [1:0]  yr_s3, q100_s3;
	logic [6:0]  r100_s3;
	logic [4:0]  era_s3;
	logic [13:0] y_s3;
	logic [8:0]  doyb_s3;
	logic [3:0]  mon_s3;
	logic [4:0]  day_s3;
	logic [16:0] hms_s3;
	logic [19:0] us_s3;

	always_comb begin
		r100_14 = yr_s2 - 14'(q100_s2) * 14'd100;
		pera    = y_s2 * R400;
		k       = 11'(mp_s2) * 11'd153 + 11'd2;
		pk      = k * R5;
	end

	always_ff @(posedge clk) begin
		ok_s3   <= ok_s2;
		yr_s3   <= yr_s2[1:0];
		q100_s3 <= q100_s2[1:0];
		r100_s3 <= r100_14[6:0];
		era_s3  <= pera[27:23];
		y_s3    <= y_s2;
		doyb_s3 <= pk[22:14];
		mon_s3  <= mon_s2;
		day_s3  <= day_s2;
		hms_s3  <= hms_s2;
		us_s3   <= us_s2;
	end

	// stage 4: month length check, year of era, day of year
	logic        leap;
	logic [13:0] yoe14;
	logic        ok_s4;
	logic [8:0]  yoe_s4, doy_s4;
	logic [4:0]  era_s4;
	logic [16:0] hms_s4;
	logic [19:0] us_s4;

	always_comb begin
		leap  = ((yr_s3 == 2'd0) && (r100_s3 != 7'd0))
			|| ((r100_s3 == 7'd0) && (q100_s3 == 2'd0));
		yoe14 = y_s3 - 14'(era_s3) * 14'd400;
	end

	always_ff @(posedge clk) begin
		ok_s4  <= ok_s3 && (day_s3 < month_len(mon_s3, leap));
		yoe_s4 <= yoe14[8:0];
		doy_s4 <= doyb_s3 + 9'(day_s3);
		era_s4 <= era_s3;
		hms_s4 <= hms_s3;
		us_s4  <= us_s3;
	end

	// stage 5: centuries in era
	logic [18:0] pq;
	logic        ok_s5;
	logic [8:0]  yoe_s5, doy_s5;
	logic [1:0]  yq_s5;
	logic [4:0]  era_s5;
	logic [16:0] hms_s5;
	logic [19:0] us_s5;

	assign pq = yoe_s4 * R100;

	always_ff @(posedge clk) begin
		ok_s5  <= ok_s4;
		yoe_s5 <= yoe_s4;
		doy_s5 <= doy_s4;
		yq_s5  <= pq[17:16];
		era_s5 <= era_s4;
		hms_s5 <= hms_s4;
		us_s5  <= us_s4;
	end

	// stage 6: day of era
	logic        ok_s6;
	logic [17:0] doe_s6;
	logic [4:0]  era_s6;
	logic [16:0] hms_s6;
	logic [19:0] us_s6;

	always_ff @(posedge clk) begin
		ok_s6  <= ok_s5;
		doe_s6 <= 18'(yoe_s5) * 18'd365 + 18'(yoe_s5[8:2]) - 18'(yq_s5) + 18'(doy_s5);
		era_s6 <= era_s5;
		hms_s6 <= hms_s5;
		us_s6  <= us_s5;
	end

	// stage 7: day count since year 1
	logic        ok_s7;
	logic [21:0] dp_s7;
	logic [16:0] hms_s7;
	logic [19:0] us_s7;

	always_ff @(posedge clk) begin
		ok_s7  <= ok_s6;
		dp_s7  <= 22'(era_s6) * 22'd146097 + 22'(doe_s6) - 22'd306;
		hms_s7 <= hms_s6;
		us_s7  <= us_s6;
	end

	// stage 8: epoch seconds, weekday quotient
	logic signed [22:0] days;
	logic signed [39:0] psec;
	logic [21:0]        d1;
	logic [44:0]        pw;
	logic               ok_s8;
	logic signed [39:0] sec_s8;
	logic [21:0]        d1_s8;
	logic [18:0]        wq_s8;
	logic [19:0]        us_s8;

	always_comb begin
		days = $signed({1'b0, dp_s7}) - 23'sd719162;
		psec = 40'(days) * 40'sd86400;
		d1   = dp_s7 + 22'd1;
		pw   = d1 * R7;
	end

	always_ff @(posedge clk) begin
		ok_s8  <= ok_s7;
		sec_s8 <= psec + $signed({23'd0, hms_s7});
		d1_s8  <= d1;
		wq_s8  <= pw[43:25];
		us_s8  <= us_s7;
	end

	// stage 9: fraction takes the sign of the seconds, weekday
	logic     carry;
	logic [21:0] wd22;
	sec_res_t res_s9;
	sec_res_t dly_q [PAD];

	always_comb begin
		carry = sec_s8[39] && (us_s8 != 20'd0);
		wd22  = d1_s8 - 22'(wq_s8) * 22'd7;
	end

	always_ff @(posedge clk) begin
		res_s9.ok       <= ok_s8;
		res_s9.seconds  <= carry ? sec_s8[38:0] + 39'sd1 : sec_s8[38:0];
		res_s9.fraction <= carry ? $signed({1'b0, us_s8}) - $signed({1'b0, USEC_PER_SEC})
			: $signed({1'b0, us_s8});
		res_s9.weekday  <= wd22[2:0];
	end

	// delay line to match the date path
	always_ff @(posedge clk) begin
		dly_q[0] <= res_s9;
		for (int i = 1; i < PAD; i++) begin
			dly_q[i] <= dly_q[i-1];
		end
	end

	assign res = dly_q[PAD-1];

endmodule
